FILE: hw/rtl/decimal_amount_to_cents_parser_unit_defines.svh
// Assertion macros used by the checker file of this block.
// Both macros expect signals named clk and arst_n in the scope where they are used.
`ifndef DECIMAL_AMOUNT_TO_CENTS_PARSER_UNIT_DEFINES_SVH
`define DECIMAL_AMOUNT_TO_CENTS_PARSER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DACP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dacp: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define DACP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dacp: next-cycle check failed");

`endif

FILE: hw/rtl/dacp_pkg.sv
package dacp_pkg;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       line_last;
	} char_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [38:0] cents;
	} res_item_t;

	// Line state as seen by the byte scanner.
	typedef enum logic [1:0] {
		PH_LEAD,
		PH_BODY,
		PH_TRAIL
	} phase_t;

	// Everything the range check and cents conversion need about a finished line.
	// The status here is final except that an ok line may still turn out of range.
	typedef struct packed {
		logic [2:0]  status;
		logic        overflow;
		logic [31:0] whole;
		logic [6:0]  frac;
	} scan_res_t;

	localparam logic [2:0] ST_OK           = 3'd0;
	localparam logic [2:0] ST_EMPTY        = 3'd1;
	localparam logic [2:0] ST_BAD_CHAR     = 3'd2;
	localparam logic [2:0] ST_EXTRA_SEP    = 3'd3;
	localparam logic [2:0] ST_TOO_MANY_DEC = 3'd4;
	localparam logic [2:0] ST_NO_DIGIT     = 3'd5;
	localparam logic [2:0] ST_RANGE        = 3'd6;

	localparam logic [31:0] MAX_UNITS_RST = 32'd1000000;
	localparam logic [31:0] WHOLE_LIMIT   = 32'hFFFF_FFFF;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [1:0] FRAC_DIGITS_MAX = 2'd2;

endpackage

FILE: hw/rtl/dacp_scan.sv
module dacp_scan (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  dacp_pkg::char_item_t   item,
	output dacp_pkg::scan_res_t    res
);
	import dacp_pkg::*;

	phase_t      phase_q, phase_d;
	logic        sep_q, sep_d;
	logic [1:0]  fd_q, fd_d;
	logic        dig_q, dig_d;
	logic [2:0]  err_q, err_d;
	logic [31:0] whole_q, whole_d;
	logic [6:0]  frac_q, frac_d;
	logic        ovf_q, ovf_d;
	logic        ended_q, ended_d;

	logic [7:0]  c;
	logic [3:0]  digit;
	logic [35:0] whole_x10;
	logic        is_blank;
	logic        is_digit;

	always_comb begin
		c         = item.char_byte;
		digit     = c[3:0];
		is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
		is_blank  = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) ||
		            (c == CH_FF) || (c == CH_CR);
		whole_x10 = ({4'b0, whole_q} << 3) + ({4'b0, whole_q} << 1) + {32'b0, digit};

		phase_d = phase_q;
		sep_d   = sep_q;
		fd_d    = fd_q;
		dig_d   = dig_q;
		err_d   = err_q;
		whole_d = whole_q;
		frac_d  = frac_q;
		ovf_d   = ovf_q;
		ended_d = ended_q;

		if (!ended_q) begin
			if (c == CH_NUL || c == CH_LF) begin
				ended_d = 1'b1;
			end else if (err_q != ST_OK) begin
				// The first error sticks for the rest of the line.
			end else if (is_blank) begin
				if (phase_q == PH_BODY) begin
					phase_d = PH_TRAIL;
				end
			end else if (phase_q == PH_TRAIL) begin
				err_d = ST_BAD_CHAR;
			end else begin
				phase_d = PH_BODY;
				if (is_digit) begin
					dig_d = 1'b1;
					if (sep_q) begin
						if (fd_q >= FRAC_DIGITS_MAX) begin
							err_d = ST_TOO_MANY_DEC;
						end else begin
							frac_d = (frac_q << 3) + (frac_q << 1) + {3'b0, digit};
							fd_d   = fd_q + 2'd1;
						end
					end else if (!ovf_q) begin
						if (whole_x10[35:32] != 4'd0) begin
							ovf_d   = 1'b1;
							whole_d = WHOLE_LIMIT;
						end else begin
							whole_d = whole_x10[31:0];
						end
					end
				end else if (c == CH_DOT || c == CH_COMMA) begin
					if (sep_q) begin
						err_d = ST_EXTRA_SEP;
					end else begin
						sep_d = 1'b1;
					end
				end else begin
					err_d = ST_BAD_CHAR;
				end
			end
		end

		// A single fraction digit counts as tenths.
		res.frac     = (fd_d == 2'd1) ? ((frac_d << 3) + (frac_d << 1)) : frac_d;
		res.whole    = whole_d;
		res.overflow = ovf_d;
		priority if (phase_d == PH_LEAD) begin
			res.status = ST_EMPTY;
		end else if (err_d != ST_OK) begin
			res.status = err_d;
		end else if (!dig_d) begin
			res.status = ST_NO_DIGIT;
		end else begin
			res.status = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			sep_q   <= 1'b0;
			fd_q    <= 2'd0;
			dig_q   <= 1'b0;
			err_q   <= ST_OK;
			whole_q <= '0;
			frac_q  <= '0;
			ovf_q   <= 1'b0;
			ended_q <= 1'b0;
		end else if (step) begin
			if (item.line_last) begin
				phase_q <= PH_LEAD;
				sep_q   <= 1'b0;
				fd_q    <= 2'd0;
				dig_q   <= 1'b0;
				err_q   <= ST_OK;
				whole_q <= '0;
				frac_q  <= '0;
				ovf_q   <= 1'b0;
				ended_q <= 1'b0;
			end else begin
				phase_q <= phase_d;
				sep_q   <= sep_d;
				fd_q    <= fd_d;
				dig_q   <= dig_d;
				err_q   <= err_d;
				whole_q <= whole_d;
				frac_q  <= frac_d;
				ovf_q   <= ovf_d;
				ended_q <= ended_d;
			end
		end
	end

endmodule

FILE: hw/rtl/dacp_finish.sv
module dacp_finish (
	input  dacp_pkg::scan_res_t snap,
	input  logic [31:0]         max_units,
	output dacp_pkg::res_item_t item
);
	import dacp_pkg::*;

	logic        out_of_range;
	logic [38:0] whole_ext;

	always_comb begin
		whole_ext    = {7'b0, snap.whole};
		out_of_range = snap.overflow || (snap.whole > max_units) ||
		               ((snap.whole == max_units) && (snap.frac != 7'd0));
		item.status  = snap.status;
		item.cents   = '0;
		if (snap.status == ST_OK) begin
			if (out_of_range) begin
				item.status = ST_RANGE;
			end else begin
				// whole * 100 as 64 + 32 + 4.
				item.cents = (whole_ext << 6) + (whole_ext << 5) + (whole_ext << 2) +
				             {32'b0, snap.frac};
			end
		end
	end

endmodule

FILE: hw/rtl/decimal_amount_to_cents_parser_unit.sv
// Decimal amount parser: a text line arrives one byte per item, with line_last set on
// its final byte, and the block answers each line with one result item holding a status
// code and the amount in exact integer cents (cents is zero unless the status is ok).
// A NUL or newline byte ends the content, and the rest of the line is then ignored.
// Leading and trailing blanks are skipped, the body takes digits with at most one '.'
// or ',' and at most two decimals, and amounts above max_units whole units are flagged
// out of range. The block takes one byte per clock cycle while char_stall is low; it
// stalls when a line's last byte finds the line snapshot register full. That byte goes
// through the input and line snapshot registers before the result register shows the
// result. The sustained rate is set by the per-byte accumulator update (a times-ten
// and add on the 32-bit whole part), which closes on itself every cycle. max_units
// resets to one million and is written through cfg_wr_en and cfg_wr_data; the user
// must write it only while no line is in flight, as the block does not enforce this.
module decimal_amount_to_cents_parser_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 char_valid,
	output logic                 char_stall,
	input  dacp_pkg::char_item_t char_item,
	output logic                 res_valid,
	input  logic                 res_stall,
	output dacp_pkg::res_item_t  res_item,
	input  logic                 cfg_wr_en,
	input  logic [31:0]          cfg_wr_data
);
	import dacp_pkg::*;

	// Configuration register.
	logic [31:0] max_units_q;

	// Stage 1 holds the accepted byte while the scanner folds it into the line state.
	logic       valid_s1;
	char_item_t item_s1;

	// Stage 2 holds the summary of a finished line.
	logic      valid_s2;
	scan_res_t snap_s2;

	// The result register.
	logic      res_valid_q;
	res_item_t res_q;

	scan_res_t scan_res;
	res_item_t fin_item;
	logic      res_free;
	logic      load_res;
	logic      s2_free;
	logic      s1_go;
	logic      char_acc;

	// Each stage moves on when the one after it is empty or is emptying in the
	// same cycle. Only the last byte of a line needs room in stage 2; every other
	// byte just updates the line state and leaves.
	always_comb begin
		res_free   = !res_valid_q || !res_stall;
		load_res   = valid_s2 && res_free;
		s2_free    = !valid_s2 || load_res;
		s1_go      = valid_s1 && (!item_s1.line_last || s2_free);
		char_stall = valid_s1 && !s1_go;
		char_acc   = char_valid && !char_stall;
	end

	dacp_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (s1_go),
		.item   (item_s1),
		.res    (scan_res)
	);

	dacp_finish u_finish (
		.snap      (snap_s2),
		.max_units (max_units_q),
		.item      (fin_item)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_units_q <= MAX_UNITS_RST;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				max_units_q <= cfg_wr_data;
			end
			if (char_acc) begin
				valid_s1 <= 1'b1;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end
			if (s1_go && item_s1.line_last) begin
				valid_s2 <= 1'b1;
			end else if (load_res) begin
				valid_s2 <= 1'b0;
			end
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers carry no reset; their valid flags guard them.
	always_ff @(posedge clk) begin
		if (char_acc) begin
			item_s1 <= char_item;
		end
		if (s1_go && item_s1.line_last) begin
			snap_s2 <= scan_res;
		end
		if (load_res) begin
			res_q <= fin_item;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

endmodule

FILE: hw/rtl/dacp_checker.sv
`include "decimal_amount_to_cents_parser_unit_defines.svh"

module dacp_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 char_valid,
	input logic                 char_stall,
	input dacp_pkg::char_item_t char_item,
	input logic                 res_valid,
	input logic                 res_stall,
	input dacp_pkg::res_item_t  res_item
);
	import dacp_pkg::*;

	// Lines whose last byte was accepted but whose result has not been taken.
	logic [2:0] pend_q;
	logic       line_in;
	logic       line_out;

	always_comb begin
		line_in  = char_valid && !char_stall && char_item.line_last;
		line_out = res_valid && !res_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 3'd0;
		end else begin
			pend_q <= pend_q + {2'b0, line_in} - {2'b0, line_out};
		end
	end

	`DACP_ASSERT_NXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res_item))
	`DACP_ASSERT_IMP(a_err_no_cents, res_valid && (res_item.status != ST_OK), res_item.cents == 39'd0)
	`DACP_ASSERT_IMP(a_res_has_line, res_valid, pend_q != 3'd0)
	`DACP_ASSERT_IMP(a_idle_no_stall, pend_q == 3'd0, !char_stall)

endmodule

bind decimal_amount_to_cents_parser_unit dacp_checker u_dacp_checker (.*);
